// ===== rtl/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned ValueWidthDef = 31;
  localparam int unsigned SumW          = 63;
  localparam int unsigned CountW        = 32;
  // digits of the remainder unit retired per cycle
  localparam int unsigned DigitBits     = 4;

  typedef enum logic [1:0] {
    CLS_SMALL = 2'd0,  // zero or one
    CLS_EVEN  = 2'd1,  // even and above two
    CLS_TRIAL = 2'd2   // two, or odd above one: tested with odd trial divisors
  } psc_cls_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } psc_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } psc_qstat_t;

endpackage

// ===== rtl/psc_in_if.sv =====
interface psc_in_if #(
  parameter int unsigned VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/psc_out_if.sv =====
interface psc_out_if;
  logic        valid;
  logic        ready;
  logic        is_prime;
  logic [62:0] prime_sum;
  logic [31:0] prime_count;
  logic        batch_end;

  modport source (output valid, output is_prime, output prime_sum, output prime_count,
                  output batch_end, input ready);
  modport sink   (input valid, input is_prime, input prime_sum, input prime_count,
                  input batch_end, output ready);
endinterface

// ===== rtl/psc_front.sv =====
module psc_front import psc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  psc_in_if.sink                 in_i,
  input  psc_qstat_t             qstat_i,
  output logic                   push_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   last_o,
  output psc_cls_e               cls_o
);

  localparam logic [VALUE_WIDTH-1:0] Two = VALUE_WIDTH'(2);

  assign in_i.ready = !qstat_i.full;
  assign push_o     = in_i.valid && !qstat_i.full;
  assign value_o    = in_i.value;
  assign last_o     = in_i.last;

  always_comb begin
    if (in_i.value[VALUE_WIDTH-1:1] == '0) begin
      cls_o = CLS_SMALL;
    end else if (!in_i.value[0] && (in_i.value != Two)) begin
      cls_o = CLS_EVEN;
    end else begin
      cls_o = CLS_TRIAL;
    end
  end

endmodule

// ===== rtl/psc_queue.sv =====
module psc_queue import psc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_i,
  input  psc_cls_e               cls_i,
  input  logic                   pop_i,
  output psc_qstat_t             qstat_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   last_o,
  output psc_cls_e               cls_o
);

  logic [VALUE_WIDTH-1:0] value_q [2];
  logic                   last_q  [2];
  psc_cls_e               cls_q   [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;

  assign value_o = value_q[rd_ptr_q];
  assign last_o  = last_q[rd_ptr_q];
  assign cls_o   = cls_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      value_q[wr_ptr_q] <= value_i;
      last_q[wr_ptr_q]  <= last_i;
      cls_q[wr_ptr_q]   <= cls_i;
    end
  end

endmodule

// ===== rtl/psc_back.sv =====
module psc_back import psc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  psc_qstat_t             qstat_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_i,
  input  psc_cls_e               cls_i,
  output logic                   pop_o,
  psc_out_if.source              out_o
);

  localparam int unsigned Steps = (VALUE_WIDTH + DigitBits - 1) / DigitBits;
  localparam int unsigned PadW  = Steps * DigitBits;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam int unsigned RemW  = VALUE_WIDTH + 1;
  localparam int unsigned SqW   = VALUE_WIDTH + 2;
  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);
  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  psc_state_e             state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic                   last_q, last_d;
  logic                   prime_q, prime_d;
  logic [VALUE_WIDTH-1:0] dv_q, dv_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [PadW-1:0]        nsh_q, nsh_d;
  logic [StepW-1:0]       step_q, step_d;

  logic                   out_valid_q;
  logic                   out_prime_q;
  logic [SumW-1:0]        out_sum_q;
  logic [CountW-1:0]      out_cnt_q;
  logic                   out_end_q;
  logic [SumW-1:0]        sum_acc_q;
  logic [CountW-1:0]      cnt_acc_q;

  logic                   out_free, emit;
  logic [RemW-1:0]        rem_next;
  logic [SumW:0]          sum_add;
  logic [SumW-1:0]        sum_new;
  logic [CountW-1:0]      cnt_new;

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = (state_q == S_DONE) && out_free;
  assign pop_o    = (state_q == S_IDLE) && !qstat_i.empty;

  // restoring remainder, one digit group of n per cycle
  always_comb begin
    logic [RemW-1:0] r;
    r = rem_q;
    for (int k = 0; k < int'(DigitBits); k++) begin
      r = {r[RemW-2:0], nsh_q[PadW-1-k]};
      if (r >= RemW'(dv_q)) begin
        r = r - RemW'(dv_q);
      end
    end
    rem_next = r;
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    last_d  = last_q;
    prime_d = prime_q;
    dv_d    = dv_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    nsh_d   = nsh_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          n_d     = value_i;
          last_d  = last_i;
          prime_d = 1'b0;
          dv_d    = VALUE_WIDTH'(3);
          sq_d    = SqW'(9);
          state_d = (cls_i == CLS_TRIAL) ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        if (sq_q > SqW'(n_q)) begin
          prime_d = 1'b1;
          state_d = S_DONE;
        end else begin
          rem_d   = '0;
          nsh_d   = PadW'(n_q);
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = rem_next;
        nsh_d  = nsh_q << DigitBits;
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          if (rem_next == '0) begin
            state_d = S_DONE;
          end else begin
            // next odd divisor: (d+2)^2 = d^2 + 4d + 4
            sq_d    = sq_q + {dv_q, 2'b00} + SqW'(4);
            dv_d    = dv_q + VALUE_WIDTH'(2);
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    sum_add = {1'b0, sum_acc_q} + (SumW + 1)'(n_q);
    sum_new = sum_acc_q;
    cnt_new = cnt_acc_q;
    if (prime_q) begin
      sum_new = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
      cnt_new = (cnt_acc_q == CountMax) ? cnt_acc_q : cnt_acc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sum_acc_q   <= '0;
      cnt_acc_q   <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        sum_acc_q   <= last_q ? '0 : sum_new;
        cnt_acc_q   <= last_q ? '0 : cnt_new;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    last_q  <= last_d;
    prime_q <= prime_d;
    dv_q    <= dv_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    nsh_q   <= nsh_d;
    step_q  <= step_d;
    if (emit) begin
      out_prime_q <= prime_q;
      out_sum_q   <= sum_new;
      out_cnt_q   <= cnt_new;
      out_end_q   <= last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_prime    = out_prime_q;
  assign out_o.prime_sum   = out_sum_q;
  assign out_o.prime_count = out_cnt_q;
  assign out_o.batch_end   = out_end_q;

endmodule

// ===== rtl/prime_sum_and_count_top.sv =====
// channel  dir  fields                                       accepted when
// in_i     in   value[VALUE_WIDTH-1:0], last                 valid && ready
// out_o    out  is_prime, prime_sum[62:0], prime_count[31:0],  valid && ready
//               batch_end
// zero, one and even words above two skip the trial divisors and are reported as not prime
// other words test odd divisors d = 3, 5, ... while d*d <= n, stopping at the first
// one that divides n; each divisor passes through S_CHECK and then S_DIV, the
// 4-bit-per-cycle remainder unit, which is the one remainder loop for all divisors
// reset clears the queue, the output register and both batch totals
// the 2-word queue keeps taking words while the back end divides or its result waits
module prime_sum_and_count_top import psc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psc_in_if.sink    in_i,
  psc_out_if.source out_o
);

  psc_qstat_t             qstat;
  logic                   push, pop;
  logic [VALUE_WIDTH-1:0] f_value, q_value;
  logic                   f_last, q_last;
  psc_cls_e               f_cls, q_cls;

  psc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .value_o (f_value),
    .last_o  (f_last),
    .cls_o   (f_cls)
  );

  psc_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .value_i (f_value),
    .last_i  (f_last),
    .cls_i   (f_cls),
    .pop_i   (pop),
    .qstat_o (qstat),
    .value_o (q_value),
    .last_o  (q_last),
    .cls_o   (q_cls)
  );

  psc_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .value_i (q_value),
    .last_i  (q_last),
    .cls_i   (q_cls),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_qstat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> !qstat.empty)
    else $error("queue empty after push");
`endif

endmodule
